// File: rtl/stc_pkg.sv
`default_nettype none
package stc_pkg;

	localparam int MAX_LEN    = 64;
	localparam int VALUE_BITS = 16;
	localparam int ELEM_W     = 16;
	localparam int ADDR_W     = $clog2(MAX_LEN);
	localparam int CNT_W      = $clog2(MAX_LEN + 1);
	localparam int SUM_W      = VALUE_BITS + 1;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [PADDR_W-3:0] REG_CHECK_MODE = 1'b0;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic signed [SUM_W-1:0]      sum_t;
	typedef logic [ADDR_W-1:0]            addr_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	typedef enum logic [2:0] {
		RD_I,
		RD_J,
		RD_LAST,
		RD_K0,
		RD_KN
	} rd_sel_t;

	typedef struct packed {
		logic    idle;
		logic    load;
		logic    start;
		rd_sel_t rd_sel;
		logic    cap_x;
		logic    cap_y;
		logic    cap_z;
		logic    k_init;
		logic    k_step;
		logic    pair_step;
		logic    finish;
		logic    verdict;
	} stc_cmd_t;

	typedef struct packed {
		logic cfg_mode;
		logic run_mode;
		logic hit_full;
		logic hit_last;
		logic k_last;
		logic pair_last;
		logic out_free;
	} stc_status_t;

endpackage
`default_nettype wire

// File: rtl/schur_triple_checker_top.sv
// Sum-free check over a stored sequence of signed values.
// Input channel (in_valid/in_stall, element_value, is_last): one element per
// transaction, one per cycle while loading. Up to MAX_LEN elements are kept;
// later ones are dropped and reported through overflowed.
// The transaction with is_last set closes the sequence and starts the search;
// in_stall stays high until the verdict is in the output register.
// Output channel (out_valid/out_stall, sum_free, overflowed): one transaction
// per sequence. The result register holds while out_stall is high, and a new
// sequence may load meanwhile; its search waits at the end for the register.
// Search over n stored elements, all reads from the single read port of the
// value store: check_mode 0 (all triples) walks n(n+1)/2 pairs and reads all
// n elements for each pair; check_mode 1 (triples with the last element)
// walks the same pairs after reading the last element once. A triple found
// ends the search at once.
// Reset: empty sequence, no pending result, check_mode = 1. Configuration is
// an APB slave, register check_mode at address 0.
`default_nettype none
module schur_triple_checker_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [stc_pkg::ELEM_W-1:0]  element_value,
	input  wire logic                        is_last,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             sum_free,
	output logic                             overflowed,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [stc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [stc_pkg::PDATA_W-1:0] pwdata,
	output logic      [stc_pkg::PDATA_W-1:0] prdata,
	output logic                             pready
);
	import stc_pkg::*;

	logic        check_mode_q;
	logic        reg_hit;
	stc_cmd_t    cmd;
	stc_status_t status;

	assign pready  = 1'b1;
	assign reg_hit = paddr[PADDR_W-1:2] == REG_CHECK_MODE;
	assign prdata  = reg_hit ? {{(PDATA_W-1){1'b0}}, check_mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_mode_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			check_mode_q <= pwdata[0];
		end
	end

	assign in_stall = !cmd.idle;

	stc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.is_last (is_last),
		.status  (status),
		.cmd     (cmd)
	);

	stc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.element_value(element_value),
		.check_mode   (check_mode_q),
		.cmd          (cmd),
		.out_stall    (out_stall),
		.status       (status),
		.out_valid    (out_valid),
		.sum_free     (sum_free),
		.overflowed   (overflowed)
	);

endmodule
`default_nettype wire

// File: rtl/stc_ram.sv
`default_nettype none
module stc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/stc_ctrl.sv
`default_nettype none
module stc_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 is_last,
	input  wire stc_pkg::stc_status_t status,
	output stc_pkg::stc_cmd_t         cmd
);
	import stc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LZ,
		S_LZC,
		S_RI,
		S_RJ,
		S_CY,
		S_FK,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   verdict_q, verdict_d;

	always_comb begin
		cmd       = '0;
		cmd.rd_sel = RD_I;
		cmd.verdict = verdict_q;
		state_d   = state_q;
		verdict_d = verdict_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (is_last) begin
						cmd.start = 1'b1;
						state_d = status.cfg_mode ? S_LZ : S_RI;
					end
				end
			end
			S_LZ: begin
				cmd.rd_sel = RD_LAST;
				state_d = S_LZC;
			end
			S_LZC: begin
				cmd.cap_z = 1'b1;
				cmd.rd_sel = RD_I;
				state_d = S_RJ;
			end
			S_RI: begin
				cmd.rd_sel = RD_I;
				state_d = S_RJ;
			end
			S_RJ: begin
				cmd.cap_x = 1'b1;
				cmd.rd_sel = RD_J;
				state_d = S_CY;
			end
			S_CY: begin
				if (status.run_mode) begin
					if (status.hit_last) begin
						verdict_d = 1'b0;
						state_d = S_DONE;
					end else if (status.pair_last) begin
						verdict_d = 1'b1;
						state_d = S_DONE;
					end else begin
						cmd.pair_step = 1'b1;
						state_d = S_RI;
					end
				end else begin
					cmd.cap_y = 1'b1;
					cmd.rd_sel = RD_K0;
					cmd.k_init = 1'b1;
					state_d = S_FK;
				end
			end
			S_FK: begin
				cmd.rd_sel = RD_KN;
				cmd.k_step = 1'b1;
				if (status.hit_full) begin
					verdict_d = 1'b0;
					state_d = S_DONE;
				end else if (status.k_last) begin
					if (status.pair_last) begin
						verdict_d = 1'b1;
						state_d = S_DONE;
					end else begin
						cmd.pair_step = 1'b1;
						state_d = S_RI;
					end
				end
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			verdict_q <= 1'b1;
		end else begin
			state_q   <= state_d;
			verdict_q <= verdict_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/stc_dp.sv
`default_nettype none
module stc_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [stc_pkg::ELEM_W-1:0] element_value,
	input  wire logic                       check_mode,
	input  wire stc_pkg::stc_cmd_t          cmd,
	input  wire logic                       out_stall,
	output stc_pkg::stc_status_t            status,
	output logic                            out_valid,
	output logic                            sum_free,
	output logic                            overflowed
);
	import stc_pkg::*;

	cnt_t   cnt_q;
	logic   ovf_q;
	logic   mode_q;
	addr_t  i_q, j_q, k_q;
	value_t x_q, y_q, z_q;
	logic   out_valid_q, sum_free_q, overflowed_q;

	addr_t  last_idx;
	addr_t  raddr;
	logic   [VALUE_BITS-1:0] rdata;
	value_t rd_val;
	logic   room;
	logic   we;

	assign room     = cnt_q < cnt_t'(MAX_LEN);
	assign we       = cmd.load && room;
	assign last_idx = addr_t'(cnt_q - cnt_t'(1));
	assign rd_val   = value_t'(rdata);

	always_comb begin
		unique case (cmd.rd_sel)
			RD_I:    raddr = i_q;
			RD_J:    raddr = j_q;
			RD_LAST: raddr = last_idx;
			RD_K0:   raddr = '0;
			RD_KN:   raddr = addr_t'(k_q + addr_t'(1));
			default: raddr = '0;
		endcase
	end

	stc_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(MAX_LEN)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(addr_t'(cnt_q)),
		.wdata(element_value[VALUE_BITS-1:0]),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		status.cfg_mode  = check_mode;
		status.run_mode  = mode_q;
		status.hit_full  = sum_t'(rd_val) == sum_t'(x_q) + sum_t'(y_q);
		status.hit_last  = (sum_t'(rd_val) == sum_t'(x_q) + sum_t'(z_q))
			|| (sum_t'(x_q) == sum_t'(rd_val) + sum_t'(z_q))
			|| (sum_t'(z_q) == sum_t'(x_q) + sum_t'(rd_val));
		status.k_last    = k_q == last_idx;
		status.pair_last = (i_q == last_idx) && (j_q == last_idx);
		status.out_free  = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.load) begin
				if (room) begin
					cnt_q <= cnt_q + cnt_t'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= check_mode;
			i_q    <= '0;
			j_q    <= '0;
		end else if (cmd.pair_step) begin
			if (j_q == last_idx) begin
				i_q <= addr_t'(i_q + addr_t'(1));
				j_q <= addr_t'(i_q + addr_t'(1));
			end else begin
				j_q <= addr_t'(j_q + addr_t'(1));
			end
		end
		if (cmd.k_init) begin
			k_q <= '0;
		end else if (cmd.k_step) begin
			k_q <= addr_t'(k_q + addr_t'(1));
		end
		if (cmd.cap_x) begin
			x_q <= rd_val;
		end
		if (cmd.cap_y) begin
			y_q <= rd_val;
		end
		if (cmd.cap_z) begin
			z_q <= rd_val;
		end
		if (cmd.finish) begin
			sum_free_q   <= cmd.verdict;
			overflowed_q <= ovf_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sum_free   = sum_free_q;
	assign overflowed = overflowed_q;

endmodule
`default_nettype wire

// File: test/tb_schur_triple_checker_top.sv
`timescale 1ns / 100ps
module tb_schur_triple_checker_top;
	import stc_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000000;
	localparam int TOTAL_ELEMENTS = 1300;
	localparam int SETTLE_CYCLES  = 10;
	localparam logic [PADDR_W-1:0] MODE_ADDR  = {REG_CHECK_MODE, 2'b00};
	localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(MODE_ADDR + 4);

	typedef enum bit {
		MODE_ALL  = 1'b0,
		MODE_LAST = 1'b1
	} mode_t;

	typedef enum bit {
		ROW_ELEM,
		ROW_CFG
	} row_kind_t;

	typedef enum int {
		STYLE_RANDOM,
		STYLE_SMALL,
		STYLE_ODD,
		STYLE_EXTREME,
		STYLE_PLANTED
	} fill_style_t;

	typedef struct packed {
		logic clean;
		logic truncated;
	} verdict_t;

	typedef struct {
		row_kind_t            kind;
		logic [PADDR_W-1:0]   addr;
		int                   value;
		bit                   last;
		bit                   typed;
		bit                   clean;
		bit                   truncated;
	} stim_row_t;

	localparam int DIR_ROWS = 27;
	stim_row_t dir_rows[DIR_ROWS] = '{
		'{ROW_ELEM, MODE_ADDR, 0,      1, 1, 0, 0},
		'{ROW_ELEM, MODE_ADDR, 1,      1, 1, 1, 0},
		'{ROW_ELEM, MODE_ADDR, 32767,  1, 1, 1, 0},
		'{ROW_ELEM, MODE_ADDR, -32768, 1, 1, 1, 0},
		// sums that would wrap in 16 bits
		'{ROW_ELEM, MODE_ADDR, 16384,  0, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, 16384,  0, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, -32768, 1, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, 32767,  0, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, 32767,  0, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, -2,     1, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, -1,     0, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, 32767,  0, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, -32768, 1, 0, 0, 0},
		// unknown register index, mode must stay
		'{ROW_CFG,  SPARE_ADDR, 0,     0, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, 1,      0, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, 2,      0, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, 100,    1, 0, 0, 0},
		'{ROW_CFG,  MODE_ADDR, MODE_ALL, 0, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, 1,      0, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, 2,      0, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, 100,    1, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, 3,      0, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, 6,      1, 0, 0, 0},
		// mode switched mid-sequence, the mode at the last element decides
		'{ROW_ELEM, MODE_ADDR, 5,      0, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, 10,     0, 0, 0, 0},
		'{ROW_CFG,  MODE_ADDR, MODE_LAST, 0, 0, 0, 0},
		'{ROW_ELEM, MODE_ADDR, 7,      1, 0, 0, 0}
	};

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                in_valid      = 1'b0;
	logic                in_stall;
	logic [ELEM_W-1:0]   element_value = '0;
	logic                is_last       = 1'b0;
	logic                out_valid;
	logic                out_stall     = 1'b0;
	logic                sum_free;
	logic                overflowed;
	logic                psel          = 1'b0;
	logic                penable       = 1'b0;
	logic                pwrite        = 1'b0;
	logic [PADDR_W-1:0]  paddr         = '0;
	logic [PDATA_W-1:0]  pwdata        = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	schur_triple_checker_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.element_value (element_value),
		.is_last       (is_last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sum_free      (sum_free),
		.overflowed    (overflowed),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #10 clk = ~clk;

	// shadow of the sequence held by the block
	int       stored_vals[MAX_LEN];
	int       stored_count = 0;
	bit       dropped      = 1'b0;
	mode_t    cfg_mode     = MODE_LAST;

	verdict_t verdicts_due[$];
	verdict_t monitor_want;
	int       errors        = 0;
	int       elements_sent = 0;
	int       quiet_cycles  = 0;
	bit       gaps_on       = 1'b0;
	int       burst_left    = 0;
	logic [31:0] stall_bits  = '0;
	logic [7:0]  stall_phase = '0;

	function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		errors++;
		if (errors <= 10) begin
			$display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
		end
	endfunction

	function automatic bit all_triples_clear(int n);
		for (int a = 0; a < n; a++) begin
			for (int b = 0; b < n; b++) begin
				for (int c = b; c < n; c++) begin
					if (stored_vals[a] == stored_vals[b] + stored_vals[c]) begin
						return 1'b0;
					end
				end
			end
		end
		return 1'b1;
	endfunction

	function automatic bit final_triples_clear(int n);
		int z;
		int x;
		int y;
		z = stored_vals[n-1];
		for (int i = 0; i < n; i++) begin
			for (int j = i; j < n; j++) begin
				x = stored_vals[i];
				y = stored_vals[j];
				if (y == x + z || x == y + z || z == x + y) begin
					return 1'b0;
				end
			end
		end
		return 1'b1;
	endfunction

	// returns 1 when the element closes a sequence
	function automatic bit take_element(logic [ELEM_W-1:0] raw, bit last, output verdict_t v);
		value_t sv;
		sv = value_t'(raw[VALUE_BITS-1:0]);
		v  = '0;
		if (stored_count < MAX_LEN) begin
			stored_vals[stored_count] = int'(sv);
			stored_count++;
		end else begin
			dropped = 1'b1;
		end
		if (!last) begin
			return 1'b0;
		end
		v.clean     = (cfg_mode == MODE_ALL) ? all_triples_clear(stored_count)
		                                     : final_triples_clear(stored_count);
		v.truncated = dropped;
		stored_count = 0;
		dropped      = 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [PDATA_W-1:0] mode_word(mode_t m);
		logic [PDATA_W-1:0] w;
		w    = $urandom;
		w[0] = m;
		return w;
	endfunction

	task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [PADDR_W-1:0] a, output logic [PDATA_W-1:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= a;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			d = prdata;
			@(posedge clk);
		end while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic verify_mode_reg();
		logic [PDATA_W-1:0] rd;
		apb_read(MODE_ADDR, rd);
		if (rd !== PDATA_W'(cfg_mode)) begin
			report_mismatch("check_mode readback", PDATA_W'(cfg_mode), rd);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_register(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
		wait_idle();
		apb_write(a, d);
		if (a == MODE_ADDR) begin
			cfg_mode = mode_t'(d[0]);
		end
		verify_mode_reg();
	endtask

	task automatic send_element(input logic [ELEM_W-1:0] raw, input bit last,
	                            input bit typed, input verdict_t typed_v);
		verdict_t got;
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		in_valid      <= 1'b1;
		element_value <= raw;
		is_last       <= last;
		do @(posedge clk); while (in_stall);
		elements_sent++;
		if (take_element(raw, last, got)) begin
			verdicts_due.push_back(typed ? typed_v : got);
		end
	endtask

	task automatic send_sequence(input int len, input fill_style_t style);
		int seq[$];
		int v;
		int a;
		int b;
		for (int k = 0; k < len; k++) begin
			case (style)
				STYLE_SMALL:   v = int'($urandom_range(0, 40)) - 20;
				STYLE_ODD:     v = int'($urandom | 1);
				STYLE_EXTREME: v = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 15))
				                                        : -32768 + int'($urandom_range(0, 15));
				default:       v = int'($urandom);
			endcase
			seq.push_back(v);
		end
		if (style == STYLE_PLANTED && len >= 3) begin
			a = int'($urandom_range(0, 32000)) - 16000;
			b = int'($urandom_range(0, 32000)) - 16000;
			seq[$urandom_range(0, len - 1)] = a;
			seq[$urandom_range(0, len - 1)] = b;
			seq[$urandom_range(0, len - 1)] = a + b;
		end
		for (int k = 0; k < len; k++) begin
			send_element(ELEM_W'(seq[k]), k == len - 1, 1'b0, '0);
		end
	endtask

	// receiver stall pattern, reloaded each time stall_phase wraps to zero
	always @(posedge clk) begin
		if (stall_phase == 8'd0) begin
			case ($urandom_range(0, 3))
				0: stall_bits <= '0;
				1: stall_bits <= $urandom;
				2: stall_bits <= $urandom & $urandom;
				default: stall_bits <= $urandom | $urandom;
			endcase
		end
		out_stall   <= stall_bits[stall_phase[4:0]];
		stall_phase <= stall_phase + 8'd1;
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				report_mismatch("verdict with nothing pending", '0,
				                32'({sum_free, overflowed}));
			end else begin
				monitor_want = verdicts_due.pop_front();
				if (sum_free !== monitor_want.clean) begin
					report_mismatch("sum_free", 32'(monitor_want.clean), 32'(sum_free));
				end
				if (overflowed !== monitor_want.truncated) begin
					report_mismatch("overflowed", 32'(monitor_want.truncated),
					                32'(overflowed));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		stim_row_t   row;
		verdict_t    tv;
		mode_t       phase_mode;
		int          len;
		int          r;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		verify_mode_reg();

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_CFG) begin
				set_register(row.addr, PDATA_W'(row.value));
			end else begin
				tv = '{row.clean, row.truncated};
				send_element(ELEM_W'(row.value), row.last, row.typed, tv);
			end
		end

		// full-length and overflowing sequences in both modes
		gaps_on = 1'b1;
		set_register(MODE_ADDR, mode_word(MODE_LAST));
		send_sequence(MAX_LEN, STYLE_ODD);
		for (int k = 0; k < MAX_LEN; k++) begin
			send_element(ELEM_W'($urandom | 1), 1'b0, 1'b0, '0);
		end
		for (int k = 0; k < 5; k++) begin
			send_element((k == 4) ? '0 : ELEM_W'($urandom & 16'hfffe), k == 4, 1'b0, '0);
		end
		set_register(MODE_ADDR, mode_word(MODE_ALL));
		send_sequence(MAX_LEN, STYLE_ODD);
		send_sequence(MAX_LEN + 2, STYLE_SMALL);

		while (elements_sent < TOTAL_ELEMENTS) begin
			phase_mode = mode_t'($urandom_range(0, 1));
			if ($urandom_range(0, 3) == 0) begin
				set_register(SPARE_ADDR, $urandom);
			end
			set_register(MODE_ADDR, mode_word(phase_mode));
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(5, 20)) begin
				r = $urandom_range(0, 99);
				if (phase_mode == MODE_ALL) begin
					len = (r < 90) ? $urandom_range(1, 8) : $urandom_range(9, 20);
				end else begin
					len = (r < 75) ? $urandom_range(1, 12)
					    : (r < 96) ? $urandom_range(13, 40) : $urandom_range(MAX_LEN, MAX_LEN + 6);
				end
				send_sequence(len, fill_style_t'($urandom_range(0, 4)));
			end
		end

		wait_idle();
		repeat (40) @(posedge clk);
		errors += verdicts_due.size();
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/stc_pkg.sv
rtl/stc_ram.sv
rtl/stc_ctrl.sv
rtl/stc_dp.sv
rtl/schur_triple_checker_top.sv
test/tb_schur_triple_checker_top.sv
